@@ src/rlpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rlpd_pkg
// Types and constants shared by the RGB LED PWM mode driver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rlpd_pkg;

  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned PHASE_W   = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'hFF;
  localparam logic [LEVEL_W-1:0] LEVEL_ZERO = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE  = 2'd0,
    REG_RED   = 2'd1,
    REG_GREEN = 2'd2,
    REG_BLUE  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_STEADY    = 2'd0,
    MODE_FLASH     = 2'd1,
    MODE_HUE_CYCLE = 2'd2,
    MODE_FALLBACK  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    HUE_RED_YELLOW   = 3'd0,
    HUE_YELLOW_GREEN = 3'd1,
    HUE_GREEN_CYAN   = 3'd2,
    HUE_CYAN_BLUE    = 3'd3,
    HUE_BLUE_MAGENTA = 3'd4,
    HUE_MAGENTA_RED  = 3'd5
  } hue_t;

  typedef struct packed {
    logic hue_step;
    logic dark;
  } tick_info_t;

endpackage

`default_nettype wire

@@ src/rlpd_timing.sv @@
// ----------------------------------------------------------------------------
// rlpd_timing
// PWM tick counter, hue step divider and millisecond blink phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlpd_timing
  import rlpd_pkg::*;
#(
  parameter int unsigned BLINK_PERIOD_MS = 500,
  parameter int unsigned BLINK_DARK_MS   = 300,
  parameter int unsigned HUE_STEP_TICKS  = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               tick,
  input  wire logic               ms_strobe,
  output logic      [LEVEL_W-1:0] pwm_count,
  output tick_info_t              info
);

  logic [LEVEL_W-1:0] pwm_count_r, pwm_count_nxt;
  logic [LEVEL_W-1:0] hue_div_r, hue_div_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [LEVEL_W:0]   hue_div_inc;
  logic [PHASE_W:0]   phase_inc;

  always_comb begin
    pwm_count_nxt = pwm_count_r + 1'b1;
    hue_div_inc   = {1'b0, hue_div_r} + 1'b1;
    if (pwm_count_r == LEVEL_MAX) begin
      hue_div_nxt = '0;
    end else if (hue_div_inc == (LEVEL_W+1)'(HUE_STEP_TICKS)) begin
      hue_div_nxt = '0;
    end else begin
      hue_div_nxt = hue_div_inc[LEVEL_W-1:0];
    end

    phase_inc = {1'b0, phase_r} + 1'b1;
    phase_nxt = phase_r;
    if (ms_strobe) begin
      if (phase_inc >= (PHASE_W+1)'(BLINK_PERIOD_MS)) begin
        phase_nxt = '0;
      end else begin
        phase_nxt = phase_inc[PHASE_W-1:0];
      end
    end

    info.hue_step = (hue_div_nxt == '0);
    info.dark     = ({1'b0, phase_nxt} < (PHASE_W+1)'(BLINK_DARK_MS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pwm_count_r <= '0;
      hue_div_r   <= '0;
      phase_r     <= '0;
    end else if (tick) begin
      pwm_count_r <= pwm_count_nxt;
      hue_div_r   <= hue_div_nxt;
      phase_r     <= phase_nxt;
    end
  end

  assign pwm_count = pwm_count_r;

endmodule

`default_nettype wire

@@ src/rlpd_levels.sv @@
// ----------------------------------------------------------------------------
// rlpd_levels
// Configuration registers, mode handling and current PWM levels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rlpd_levels
  import rlpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 tick,
  input  wire tick_info_t           info,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_DAT_W-1:0] cfg_dat,
  output logic      [LEVEL_W-1:0]   level_red,
  output logic      [LEVEL_W-1:0]   level_green,
  output logic      [LEVEL_W-1:0]   level_blue
);

  mode_t              mode_r, mode_nxt;
  hue_t               hue_r, hue_nxt;
  logic [LEVEL_W-1:0] set_red_r, set_red_nxt;
  logic [LEVEL_W-1:0] set_green_r, set_green_nxt;
  logic [LEVEL_W-1:0] set_blue_r, set_blue_nxt;
  logic [LEVEL_W-1:0] lvl_red_r, lvl_red_nxt;
  logic [LEVEL_W-1:0] lvl_green_r, lvl_green_nxt;
  logic [LEVEL_W-1:0] lvl_blue_r, lvl_blue_nxt;

  always_comb begin
    mode_nxt      = mode_r;
    hue_nxt       = hue_r;
    set_red_nxt   = set_red_r;
    set_green_nxt = set_green_r;
    set_blue_nxt  = set_blue_r;
    lvl_red_nxt   = lvl_red_r;
    lvl_green_nxt = lvl_green_r;
    lvl_blue_nxt  = lvl_blue_r;

    if (tick) begin
      unique case (mode_r)
        MODE_STEADY: begin
          lvl_red_nxt   = set_red_r;
          lvl_green_nxt = set_green_r;
          lvl_blue_nxt  = set_blue_r;
        end
        MODE_FLASH: begin
          lvl_red_nxt   = info.dark ? LEVEL_ZERO : set_red_r;
          lvl_green_nxt = info.dark ? LEVEL_ZERO : set_green_r;
          lvl_blue_nxt  = info.dark ? LEVEL_ZERO : set_blue_r;
        end
        MODE_HUE_CYCLE: begin
          if (info.hue_step) begin
            unique case (hue_r)
              HUE_RED_YELLOW: begin
                if (lvl_green_r != LEVEL_MAX) lvl_green_nxt = lvl_green_r + 1'b1;
                else hue_nxt = HUE_YELLOW_GREEN;
              end
              HUE_YELLOW_GREEN: begin
                if (lvl_red_r != LEVEL_ZERO) lvl_red_nxt = lvl_red_r - 1'b1;
                else hue_nxt = HUE_GREEN_CYAN;
              end
              HUE_GREEN_CYAN: begin
                if (lvl_blue_r != LEVEL_MAX) lvl_blue_nxt = lvl_blue_r + 1'b1;
                else hue_nxt = HUE_CYAN_BLUE;
              end
              HUE_CYAN_BLUE: begin
                if (lvl_green_r != LEVEL_ZERO) lvl_green_nxt = lvl_green_r - 1'b1;
                else hue_nxt = HUE_BLUE_MAGENTA;
              end
              HUE_BLUE_MAGENTA: begin
                if (lvl_red_r != LEVEL_MAX) lvl_red_nxt = lvl_red_r + 1'b1;
                else hue_nxt = HUE_MAGENTA_RED;
              end
              HUE_MAGENTA_RED: begin
                if (lvl_blue_r != LEVEL_ZERO) lvl_blue_nxt = lvl_blue_r - 1'b1;
                else hue_nxt = HUE_RED_YELLOW;
              end
              default: hue_nxt = HUE_RED_YELLOW;
            endcase
          end
        end
        default: mode_nxt = MODE_STEADY;
      endcase
    end

    if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_MODE: begin
          mode_nxt = mode_t'(cfg_dat[1:0]);
          if (mode_t'(cfg_dat[1:0]) == MODE_HUE_CYCLE) begin
            lvl_red_nxt   = LEVEL_MAX;
            lvl_green_nxt = LEVEL_ZERO;
            lvl_blue_nxt  = LEVEL_ZERO;
          end
        end
        REG_RED:   set_red_nxt   = cfg_dat;
        REG_GREEN: set_green_nxt = cfg_dat;
        REG_BLUE:  set_blue_nxt  = cfg_dat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_STEADY;
      hue_r       <= HUE_RED_YELLOW;
      set_red_r   <= '0;
      set_green_r <= '0;
      set_blue_r  <= '0;
      lvl_red_r   <= '0;
      lvl_green_r <= '0;
      lvl_blue_r  <= '0;
    end else begin
      mode_r      <= mode_nxt;
      hue_r       <= hue_nxt;
      set_red_r   <= set_red_nxt;
      set_green_r <= set_green_nxt;
      set_blue_r  <= set_blue_nxt;
      lvl_red_r   <= lvl_red_nxt;
      lvl_green_r <= lvl_green_nxt;
      lvl_blue_r  <= lvl_blue_nxt;
    end
  end

  assign level_red   = lvl_red_r;
  assign level_green = lvl_green_r;
  assign level_blue  = lvl_blue_r;

endmodule

`default_nettype wire

@@ src/rgb_led_pwm_mode_driver_unit.sv @@
// Latency: the result of an item is valid in the cycle after it is accepted.
// Throughput: one item per cycle while out_ready is high, set by the single output register stage.
// Reset: synchronous active-low rst_n clears counters, levels, mode and colors
// to zero and empties the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// rgb_led_pwm_mode_driver_unit
// Three-channel PWM LED driver with solid, blink and rainbow modes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_led_pwm_mode_driver_unit
  import rlpd_pkg::*;
#(
  parameter int unsigned BLINK_PERIOD_MS = 500,
  parameter int unsigned BLINK_DARK_MS   = 300,
  parameter int unsigned HUE_STEP_TICKS  = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_ms_strobe,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_led_red,
  output logic                      out_led_green,
  output logic                      out_led_blue,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  logic               tick;
  logic [LEVEL_W-1:0] pwm_count;
  logic [LEVEL_W-1:0] level_red, level_green, level_blue;
  tick_info_t         info;
  logic               out_valid_r, out_valid_nxt;
  logic               red_r, green_r, blue_r;

  assign in_ready  = !out_valid_r || out_ready;
  assign tick      = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  rlpd_timing #(
    .BLINK_PERIOD_MS (BLINK_PERIOD_MS),
    .BLINK_DARK_MS   (BLINK_DARK_MS),
    .HUE_STEP_TICKS  (HUE_STEP_TICKS)
  ) u_timing (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick      (tick),
    .ms_strobe (in_ms_strobe),
    .pwm_count (pwm_count),
    .info      (info)
  );

  rlpd_levels u_levels (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (tick),
    .info        (info),
    .cfg_we      (cfg_valid),
    .cfg_idx     (cfg_index),
    .cfg_dat     (cfg_data),
    .level_red   (level_red),
    .level_green (level_green),
    .level_blue  (level_blue)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (tick) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      red_r   <= (pwm_count < level_red);
      green_r <= (pwm_count < level_green);
      blue_r  <= (pwm_count < level_blue);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_led_red   = red_r;
  assign out_led_green = green_r;
  assign out_led_blue  = blue_r;

endmodule

`default_nettype wire

@@ tb/tb_rgb_led_pwm_mode_driver_unit.sv @@
// ----------------------------------------------------------------------------
// tb_rgb_led_pwm_mode_driver_unit
// Self-checking bench for the RGB LED PWM mode driver. A tracker class keeps
// its own copy of the tick counter, millisecond phase, hue phase and levels,
// works out the pin drive of every accepted tick and compares it with what
// comes out. Directed items cover reset, color extremes, the fallback mode and
// repeated rainbow writes; a rainbow run takes a few hue steps; then
// random phases change the settings between bursts of ticks with random gaps
// and stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import rlpd_pkg::*;

localparam int unsigned PERIOD_MS = 500;
localparam int unsigned DARK_MS   = 300;
localparam int unsigned HUE_TICKS = 128;

class pwm_pin_tracker;
  mode_t              mode;
  logic [LEVEL_W-1:0] set_r, set_g, set_b;
  logic [LEVEL_W-1:0] lvl_r, lvl_g, lvl_b;
  logic [LEVEL_W-1:0] cnt;
  logic [PHASE_W-1:0] ms_pos;
  hue_t               hue;
  logic [2:0]         pending_pins[$];
  int unsigned        fail_count;

  function new();
    mode       = MODE_STEADY;
    set_r      = LEVEL_ZERO;
    set_g      = LEVEL_ZERO;
    set_b      = LEVEL_ZERO;
    lvl_r      = LEVEL_ZERO;
    lvl_g      = LEVEL_ZERO;
    lvl_b      = LEVEL_ZERO;
    cnt        = '0;
    ms_pos     = '0;
    hue        = HUE_RED_YELLOW;
    fail_count = 0;
  endfunction

  function void write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      REG_MODE: begin
        mode = mode_t'(data[1:0]);
        if (mode == MODE_HUE_CYCLE) begin
          lvl_r = LEVEL_MAX;
          lvl_g = LEVEL_ZERO;
          lvl_b = LEVEL_ZERO;
        end
      end
      REG_RED:   set_r = data;
      REG_GREEN: set_g = data;
      REG_BLUE:  set_b = data;
      default: ;
    endcase
  endfunction

  function void take_tick(logic strobe);
    pending_pins.push_back({cnt < lvl_r, cnt < lvl_g, cnt < lvl_b});
    cnt = cnt + 8'd1;
    if (strobe)
      ms_pos = (int'(ms_pos) + 1 >= PERIOD_MS) ? '0 : ms_pos + 9'd1;
    case (mode)
      MODE_STEADY: begin
        lvl_r = set_r;
        lvl_g = set_g;
        lvl_b = set_b;
      end
      MODE_FLASH: begin
        if (int'(ms_pos) < DARK_MS) begin
          lvl_r = LEVEL_ZERO;
          lvl_g = LEVEL_ZERO;
          lvl_b = LEVEL_ZERO;
        end else begin
          lvl_r = set_r;
          lvl_g = set_g;
          lvl_b = set_b;
        end
      end
      MODE_HUE_CYCLE: begin
        if (int'(cnt) % HUE_TICKS == 0) begin
          case (hue)
            HUE_RED_YELLOW:
              if (lvl_g < LEVEL_MAX) lvl_g = lvl_g + 8'd1; else hue = HUE_YELLOW_GREEN;
            HUE_YELLOW_GREEN:
              if (lvl_r > LEVEL_ZERO) lvl_r = lvl_r - 8'd1; else hue = HUE_GREEN_CYAN;
            HUE_GREEN_CYAN:
              if (lvl_b < LEVEL_MAX) lvl_b = lvl_b + 8'd1; else hue = HUE_CYAN_BLUE;
            HUE_CYAN_BLUE:
              if (lvl_g > LEVEL_ZERO) lvl_g = lvl_g - 8'd1; else hue = HUE_BLUE_MAGENTA;
            HUE_BLUE_MAGENTA:
              if (lvl_r < LEVEL_MAX) lvl_r = lvl_r + 8'd1; else hue = HUE_MAGENTA_RED;
            HUE_MAGENTA_RED:
              if (lvl_b > LEVEL_ZERO) lvl_b = lvl_b - 8'd1; else hue = HUE_RED_YELLOW;
            default: hue = HUE_RED_YELLOW;
          endcase
        end
      end
      default: mode = MODE_STEADY;
    endcase
  endfunction

  function void check_pins(logic r, logic g, logic b);
    logic [2:0] want;
    logic [2:0] got;
    string      pin;
    got = {r, g, b};
    if (pending_pins.size() == 0) begin
      fail_count++;
      $display("%0t: result with nothing pending, expected none, actual rgb=%b", $time, got);
      return;
    end
    want = pending_pins.pop_front();
    for (int k = 2; k >= 0; k--) begin
      if (got[k] !== want[k]) begin
        pin = (k == 2) ? "led_red" : (k == 1) ? "led_green" : "led_blue";
        fail_count++;
        $display("%0t: %s expected %b actual %b", $time, pin, want[k], got[k]);
      end
    end
  endfunction
endclass

module tb_rgb_led_pwm_mode_driver_unit;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_ms_strobe;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_led_red;
  logic                 out_led_green;
  logic                 out_led_blue;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  pwm_pin_tracker pins;
  bit             tx_idle;
  bit             rx_idle;
  int unsigned    rx_hold;

  rgb_led_pwm_mode_driver_unit #(
    .BLINK_PERIOD_MS(PERIOD_MS),
    .BLINK_DARK_MS  (DARK_MS),
    .HUE_STEP_TICKS (HUE_TICKS)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_ms_strobe (in_ms_strobe),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_led_red  (out_led_red),
    .out_led_green(out_led_green),
    .out_led_blue (out_led_blue),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return LEVEL_ZERO;
      1: return LEVEL_MAX;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    pins.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic strobe, input int unsigned gap);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_ms_strobe <= strobe;
    do @(posedge clk); while (in_ready !== 1'b1);
    pins.take_tick(strobe);
  endtask

  // strobe_odds out of 32: 0 never, 32 always
  task automatic run_ticks(input int unsigned n, input int unsigned strobe_odds);
    for (int unsigned i = 0; i < n; i++)
      send_tick($urandom_range(0, 31) < strobe_odds, tx_idle ? $urandom_range(0, 17) : 0);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pins.pending_pins.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : rx_side
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = rx_idle ? $urandom_range(0, 17) : 0;
      if (rx_hold != 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end
      @(negedge clk);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      pins.check_pins(out_led_red, out_led_green, out_led_blue);
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stim
    mode_t              plan [7];
    logic [CFG_DAT_W-1:0] mode_byte;
    plan = '{MODE_FLASH, MODE_STEADY, MODE_HUE_CYCLE, MODE_FALLBACK,
             MODE_FLASH, MODE_HUE_CYCLE, MODE_STEADY};
    pins         = new();
    tx_idle      = 1'b0;
    rx_idle      = 1'b0;
    rx_hold      = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_ms_strobe = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_MODE;
    cfg_data     = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state, then solid with color extremes, fallback, rainbow and blink modes
    run_ticks(2, 16);
    drain_results();
    write_reg(REG_RED, LEVEL_MAX);
    write_reg(REG_GREEN, LEVEL_ZERO);
    write_reg(REG_BLUE, 8'h80);
    run_ticks(3, 0);
    drain_results();
    write_reg(REG_MODE, 8'hFF);
    write_reg(REG_BLUE, 8'h01);
    run_ticks(2, 32);
    drain_results();
    write_reg(REG_MODE, 8'h02);
    run_ticks(3, 16);
    drain_results();
    write_reg(REG_MODE, 8'hFE);
    run_ticks(2, 16);
    drain_results();
    write_reg(REG_GREEN, 8'h7F);
    write_reg(REG_MODE, 8'h01);
    run_ticks(3, 32);

    // rainbow hue steps, back to back
    drain_results();
    write_reg(REG_MODE, 8'(MODE_HUE_CYCLE));
    run_ticks(256, 32);

    for (int ph = 0; ph < 7; ph++) begin
      drain_results();
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 3) != 0) write_reg(REG_RED, pick_level());
      if ($urandom_range(0, 3) != 0) write_reg(REG_GREEN, pick_level());
      if ($urandom_range(0, 3) != 0) write_reg(REG_BLUE, pick_level());
      mode_byte = {6'($urandom_range(0, 63)), plan[ph]};
      write_reg(REG_MODE, mode_byte);
      if (ph == 1) begin
        tx_idle = 1'b0;
        rx_hold = 80;
      end
      if (ph == 0)
        run_ticks(280, 31);
      else
        run_ticks($urandom_range(15, 30), 16);
    end

    drain_results();
    if (pins.fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
